// ===== rtl/core/smtc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smtc_pkg: shared types and constants for the sliding mode torque controller
// Register indexes, switch and mode codes, the step program of the sliding
// mode law, controller/datapath command and status structs, saturation helper.
// ----------------------------------------------------------------------------
package smtc_pkg;

   localparam int WORD_W     = 32;
   localparam int GAIN_W     = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int ACC_W      = 35;   // holds a few 32-bit terms summed
   localparam int MAG_W      = 64;   // magnitude path of the multiplier
   localparam int STEP_W     = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SURFACE_SLOPE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SWITCHING_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REACHING_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INV_BOUNDARY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INERTIA        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DAMPING        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MANUAL_TORQUE  = 3'd6;

   // switch positions
   localparam logic [1:0] SW_UNKNOWN = 2'd0;
   localparam logic [1:0] SW_UP      = 2'd1;
   localparam logic [1:0] SW_MIDDLE  = 2'd2;
   localparam logic [1:0] SW_DOWN    = 2'd3;

   // active modes
   localparam logic [1:0] MODE_OFF     = 2'd0;
   localparam logic [1:0] MODE_MANUAL  = 2'd1;
   localparam logic [1:0] MODE_SLIDING = 2'd2;

   // multiplier operand select
   localparam logic [2:0] OPND_EA    = 3'd0;
   localparam logic [2:0] OPND_EV    = 3'd1;
   localparam logic [2:0] OPND_S     = 3'd2;
   localparam logic [2:0] OPND_SP    = 3'd3;
   localparam logic [2:0] OPND_INT   = 3'd4;
   localparam logic [2:0] OPND_MV    = 3'd5;
   localparam logic [2:0] OPND_ACCEL = 3'd6;
   localparam logic [2:0] OPND_INNER = 3'd7;

   // multiplier gain select
   localparam logic [2:0] GAIN_SLOPE   = 3'd0;
   localparam logic [2:0] GAIN_SWITCH  = 3'd1;
   localparam logic [2:0] GAIN_REACH   = 3'd2;
   localparam logic [2:0] GAIN_INVPHI  = 3'd3;
   localparam logic [2:0] GAIN_INERTIA = 3'd4;
   localparam logic [2:0] GAIN_DAMP    = 3'd5;

   // what to do with a finished product
   localparam logic [2:0] POST_SURF   = 3'd0;
   localparam logic [2:0] POST_CLAMP  = 3'd1;
   localparam logic [2:0] POST_ADD    = 3'd2;
   localparam logic [2:0] POST_INNER  = 3'd3;
   localparam logic [2:0] POST_TORQUE = 3'd4;

   localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LAST  = 4'd8;

   localparam logic signed [ACC_W-1:0] ACC_S32_MAX = 35'sd2147483647;
   localparam logic signed [ACC_W-1:0] ACC_S32_MIN = -35'sd2147483648;

   typedef struct packed {
      logic [2:0] opnd_sel;
      logic [2:0] gain_sel;
      logic [2:0] post;
   } step_type;

   typedef struct packed {
      logic       load_item;
      logic       start_mul;
      logic [2:0] opnd_sel;
      logic [2:0] gain_sel;
      logic       post_en;
      logic [2:0] post;
      logic       int_update;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       mul_done;
   } status_type;

   // program of the sliding mode law, one product per step
   function automatic step_type step_op(input logic [STEP_W-1:0] step);
      step_type op;
      op = '{opnd_sel: OPND_EA, gain_sel: GAIN_SLOPE, post: POST_SURF};
      unique case (step)
         4'd0: op = '{opnd_sel: OPND_EA,    gain_sel: GAIN_SLOPE,   post: POST_SURF};
         4'd1: op = '{opnd_sel: OPND_S,     gain_sel: GAIN_INVPHI,  post: POST_CLAMP};
         4'd2: op = '{opnd_sel: OPND_EV,    gain_sel: GAIN_SLOPE,   post: POST_ADD};
         4'd3: op = '{opnd_sel: OPND_SP,    gain_sel: GAIN_SWITCH,  post: POST_ADD};
         4'd4: op = '{opnd_sel: OPND_S,     gain_sel: GAIN_REACH,   post: POST_ADD};
         4'd5: op = '{opnd_sel: OPND_INT,   gain_sel: GAIN_REACH,   post: POST_INNER};
         4'd6: op = '{opnd_sel: OPND_MV,    gain_sel: GAIN_DAMP,    post: POST_ADD};
         4'd7: op = '{opnd_sel: OPND_ACCEL, gain_sel: GAIN_INERTIA, post: POST_ADD};
         4'd8: op = '{opnd_sel: OPND_INNER, gain_sel: GAIN_INERTIA, post: POST_TORQUE};
         default: op = '{opnd_sel: OPND_EA, gain_sel: GAIN_SLOPE, post: POST_SURF};
      endcase
      return op;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > ACC_S32_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < ACC_S32_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = $signed(v[WORD_W-1:0]);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sliding_mode_torque_controller_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_mode_torque_controller_unit: integral sliding mode torque controller
// One result per control tick: disabled, manual torque or the sliding mode
// law with boundary layer, integral action and J/B feedforward.
//
//   port group  | dir | handshake          | content
//   req_*       | in  | req_valid/ready    | switches, angles, velocities, accel
//   rsp_*       | out | rsp_valid/ready    | torque, valid, mode, surface, error
//   csr_*       | in  | csr_write_en       | index 0..6, 32-bit data, no read
//
// Sliding mode: nine products run one after another through a single 32x31
// multiplier. Disabled and manual modes go straight to the result.
// Synchronous reset restores register defaults and clears the integral and
// last surface. A held result does not block the next input transfer; the
// sequencer waits on the output only when a new result finds it full.
// ----------------------------------------------------------------------------
module sliding_mode_torque_controller_unit #(
   parameter int FRAC_BITS      = 16,
   parameter int INTEGRAL_WIDTH = 48
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic        [1:0]                      req_left_switch,
   input  wire logic        [1:0]                      req_right_switch,
   input  wire logic signed [31:0]                     req_measured_angle,
   input  wire logic signed [31:0]                     req_wanted_angle,
   input  wire logic signed [31:0]                     req_measured_velocity,
   input  wire logic signed [31:0]                     req_wanted_velocity,
   input  wire logic signed [31:0]                     req_wanted_acceleration,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed      [31:0]                     rsp_drive_torque,
   output logic                                        rsp_torque_valid,
   output logic             [1:0]                      rsp_active_mode,
   output logic signed      [31:0]                     rsp_surface_value,
   output logic signed      [31:0]                     rsp_position_error,
   input  wire logic                                   csr_write_en,
   input  wire logic        [smtc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [smtc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   smtc_pkg::cmd_type    cmd;
   smtc_pkg::status_type status;

   smtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   smtc_datapath #(
      .FRAC_BITS      (FRAC_BITS),
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .csr_write_en            (csr_write_en),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .req_left_switch         (req_left_switch),
      .req_right_switch        (req_right_switch),
      .req_measured_angle      (req_measured_angle),
      .req_wanted_angle        (req_wanted_angle),
      .req_measured_velocity   (req_measured_velocity),
      .req_wanted_velocity     (req_wanted_velocity),
      .req_wanted_acceleration (req_wanted_acceleration),
      .rsp_drive_torque        (rsp_drive_torque),
      .rsp_torque_valid        (rsp_torque_valid),
      .rsp_active_mode         (rsp_active_mode),
      .rsp_surface_value       (rsp_surface_value),
      .rsp_position_error      (rsp_position_error)
   );

endmodule
`default_nettype wire

// ===== rtl/core/smtc_fxmul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smtc_fxmul: shared fixed-point gain multiplier
// |a| * gain >> FRAC_BITS, sign applied after (rounds toward zero), saturated
// to 32 bits. One 32x31 multiplier used for the high and low halves of |a|.
// Start captures |a| and gain; high product, low product, result follow in turn.
// ----------------------------------------------------------------------------
module smtc_fxmul #(
   parameter int FRAC_BITS = 16,
   parameter int OPND_W    = 48
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [OPND_W-1:0]             opnd,
   input  wire logic        [smtc_pkg::GAIN_W-1:0]   gain,
   output logic                                      done,
   output logic signed      [smtc_pkg::WORD_W-1:0]   result
);

   localparam int PROD_W = smtc_pkg::GAIN_W + 32;
   localparam logic [PROD_W-1:0] PH_LIMIT = PROD_W'(64'd1 << (FRAC_BITS - 1));

   logic                              s1_ff, s2_ff, s3_ff, done_ff;
   logic                              neg_ff;
   logic [smtc_pkg::MAG_W-1:0]        mag_ff;
   logic [smtc_pkg::GAIN_W-1:0]       gain_ff;
   logic [PROD_W-1:0]                 ph_ff, pl_ff;
   logic signed [smtc_pkg::WORD_W-1:0] result_ff, result_in;

   logic [OPND_W-1:0]                 mag_w;
   logic [31:0]                       mul_b;
   logic [PROD_W-1:0]                 prod;
   logic [smtc_pkg::MAG_W-1:0]        sum_w, q;
   logic                              ovf;

   assign mag_w = opnd[OPND_W-1] ? (~opnd + 1'b1) : opnd;
   // high half first, then low half
   assign mul_b = s1_ff ? mag_ff[63:32] : mag_ff[31:0];
   assign prod  = PROD_W'(gain_ff) * PROD_W'(mul_b);

   assign ovf   = ph_ff >= PH_LIMIT;
   assign sum_w = (64'(ph_ff) << 32) + 64'(pl_ff);
   assign q     = sum_w >> FRAC_BITS;

   always_comb begin
      if (ovf) begin
         result_in = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (neg_ff) begin
         result_in = (q > 64'h8000_0000) ? 32'sh8000_0000 : $signed(32'(64'd0 - q));
      end else begin
         result_in = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         s3_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= start;
         s2_ff   <= s1_ff;
         s3_ff   <= s2_ff;
         done_ff <= s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= opnd[OPND_W-1];
         mag_ff  <= smtc_pkg::MAG_W'(mag_w);
         gain_ff <= gain;
      end
      if (s1_ff) begin
         ph_ff <= prod;
      end
      if (s2_ff) begin
         pl_ff <= prod;
      end
      if (s3_ff) begin
         result_ff <= result_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule
`default_nettype wire

// ===== rtl/core/smtc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smtc_datapath: registers, item state and arithmetic of the controller
// Holds the configuration registers, the captured item, the surface integral
// and last surface, the shared multiplier and the result register.
// ----------------------------------------------------------------------------
module smtc_datapath #(
   parameter int FRAC_BITS      = 16,
   parameter int INTEGRAL_WIDTH = 48
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire smtc_pkg::cmd_type                      cmd,
   output smtc_pkg::status_type                        status,
   input  wire logic                                   csr_write_en,
   input  wire logic        [smtc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [smtc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic        [1:0]                      req_left_switch,
   input  wire logic        [1:0]                      req_right_switch,
   input  wire logic signed [31:0]                     req_measured_angle,
   input  wire logic signed [31:0]                     req_wanted_angle,
   input  wire logic signed [31:0]                     req_measured_velocity,
   input  wire logic signed [31:0]                     req_wanted_velocity,
   input  wire logic signed [31:0]                     req_wanted_acceleration,
   output logic signed      [31:0]                     rsp_drive_torque,
   output logic                                        rsp_torque_valid,
   output logic             [1:0]                      rsp_active_mode,
   output logic signed      [31:0]                     rsp_surface_value,
   output logic signed      [31:0]                     rsp_position_error
);

   localparam int IW    = INTEGRAL_WIDTH;
   localparam int ACC_W = smtc_pkg::ACC_W;
   localparam logic [smtc_pkg::GAIN_W-1:0] GAIN_ONE =
      smtc_pkg::GAIN_W'(64'd1 << FRAC_BITS);
   localparam logic signed [31:0] SP_ONE = $signed(32'(64'd1 << FRAC_BITS));
   localparam logic signed [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};

   // configuration
   logic        [smtc_pkg::GAIN_W-1:0] slope_ff, switch_ff, reach_ff;
   logic        [smtc_pkg::GAIN_W-1:0] invphi_ff, inertia_ff, damp_ff;
   logic signed [31:0]                 manual_ff;

   // item and working registers
   logic        [1:0]        mode_ff, mode_in;
   logic signed [31:0]       ea_ff, ev_ff, mv_ff, accel_ff;
   logic signed [31:0]       sp_ff, inner_ff, torque_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [IW-1:0]     integral_ff, integral_in;
   logic signed [31:0]       last_surface_ff;
   logic signed [IW:0]       int_sum;

   logic signed [31:0]       out_torque_ff, out_surface_ff, out_error_ff;
   logic                     out_valid_ff;
   logic        [1:0]        out_mode_ff;

   logic signed [IW-1:0]                 opnd_mux;
   logic        [smtc_pkg::GAIN_W-1:0]   gain_mux;
   logic                                 mul_done;
   logic signed [31:0]                   mul_result;
   logic signed [31:0]                   sp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff   <= GAIN_ONE;
         switch_ff  <= '0;
         reach_ff   <= '0;
         invphi_ff  <= GAIN_ONE;
         inertia_ff <= '0;
         damp_ff    <= '0;
         manual_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            smtc_pkg::REG_SURFACE_SLOPE:  slope_ff   <= csr_wdata[smtc_pkg::GAIN_W-1:0];
            smtc_pkg::REG_SWITCHING_GAIN: switch_ff  <= csr_wdata[smtc_pkg::GAIN_W-1:0];
            smtc_pkg::REG_REACHING_GAIN:  reach_ff   <= csr_wdata[smtc_pkg::GAIN_W-1:0];
            smtc_pkg::REG_INV_BOUNDARY:   invphi_ff  <= csr_wdata[smtc_pkg::GAIN_W-1:0];
            smtc_pkg::REG_INERTIA:        inertia_ff <= csr_wdata[smtc_pkg::GAIN_W-1:0];
            smtc_pkg::REG_DAMPING:        damp_ff    <= csr_wdata[smtc_pkg::GAIN_W-1:0];
            smtc_pkg::REG_MANUAL_TORQUE:  manual_ff  <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      if ((req_left_switch == smtc_pkg::SW_DOWN && req_right_switch == smtc_pkg::SW_DOWN) ||
          (req_left_switch == smtc_pkg::SW_UNKNOWN &&
           req_right_switch == smtc_pkg::SW_UNKNOWN)) begin
         mode_in = smtc_pkg::MODE_OFF;
      end else if (req_left_switch == smtc_pkg::SW_UP && req_right_switch == smtc_pkg::SW_UP) begin
         mode_in = smtc_pkg::MODE_MANUAL;
      end else begin
         mode_in = smtc_pkg::MODE_SLIDING;
      end
   end

   always_comb begin
      unique case (cmd.opnd_sel)
         smtc_pkg::OPND_EA:    opnd_mux = IW'(ea_ff);
         smtc_pkg::OPND_EV:    opnd_mux = IW'(ev_ff);
         smtc_pkg::OPND_S:     opnd_mux = IW'(last_surface_ff);
         smtc_pkg::OPND_SP:    opnd_mux = IW'(sp_ff);
         smtc_pkg::OPND_INT:   opnd_mux = integral_ff;
         smtc_pkg::OPND_MV:    opnd_mux = IW'(mv_ff);
         smtc_pkg::OPND_ACCEL: opnd_mux = IW'(accel_ff);
         smtc_pkg::OPND_INNER: opnd_mux = IW'(inner_ff);
         default:              opnd_mux = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.gain_sel)
         smtc_pkg::GAIN_SLOPE:   gain_mux = slope_ff;
         smtc_pkg::GAIN_SWITCH:  gain_mux = switch_ff;
         smtc_pkg::GAIN_REACH:   gain_mux = reach_ff;
         smtc_pkg::GAIN_INVPHI:  gain_mux = invphi_ff;
         smtc_pkg::GAIN_INERTIA: gain_mux = inertia_ff;
         smtc_pkg::GAIN_DAMP:    gain_mux = damp_ff;
         default:                gain_mux = '0;
      endcase
   end

   smtc_fxmul #(
      .FRAC_BITS (FRAC_BITS),
      .OPND_W    (IW)
   ) u_fxmul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_mul),
      .opnd   (opnd_mux),
      .gain   (gain_mux),
      .done   (mul_done),
      .result (mul_result)
   );

   // boundary layer clamp to +-1.0
   always_comb begin
      if (mul_result > SP_ONE) begin
         sp_in = SP_ONE;
      end else if (mul_result < -SP_ONE) begin
         sp_in = -SP_ONE;
      end else begin
         sp_in = mul_result;
      end
   end

   // saturating integral: overflow when the two top bits of the sum differ
   assign int_sum = (IW + 1)'(integral_ff) + (IW + 1)'(last_surface_ff);
   always_comb begin
      if (int_sum[IW] != int_sum[IW-1]) begin
         integral_in = int_sum[IW] ? INT_MIN : INT_MAX;
      end else begin
         integral_in = int_sum[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff     <= '0;
         last_surface_ff <= '0;
      end else begin
         if (cmd.int_update) begin
            integral_ff <= integral_in;
         end
         if (cmd.post_en && cmd.post == smtc_pkg::POST_SURF) begin
            last_surface_ff <= smtc_pkg::sat32(ACC_W'(mul_result) + ACC_W'(ev_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff  <= mode_in;
         ea_ff    <= smtc_pkg::sat32(ACC_W'(req_measured_angle) - ACC_W'(req_wanted_angle));
         ev_ff    <= smtc_pkg::sat32(ACC_W'(req_measured_velocity) -
                                     ACC_W'(req_wanted_velocity));
         mv_ff    <= req_measured_velocity;
         accel_ff <= req_wanted_acceleration;
      end
      if (cmd.post_en) begin
         unique case (cmd.post)
            smtc_pkg::POST_SURF:   acc_ff    <= '0;
            smtc_pkg::POST_CLAMP:  sp_ff     <= sp_in;
            smtc_pkg::POST_ADD:    acc_ff    <= acc_ff + ACC_W'(mul_result);
            smtc_pkg::POST_INNER: begin
               inner_ff <= smtc_pkg::sat32(acc_ff + ACC_W'(mul_result));
               acc_ff   <= '0;
            end
            smtc_pkg::POST_TORQUE: torque_ff <= smtc_pkg::sat32(acc_ff - ACC_W'(mul_result));
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         out_mode_ff    <= mode_ff;
         out_valid_ff   <= (mode_ff != smtc_pkg::MODE_OFF);
         out_surface_ff <= last_surface_ff;
         out_error_ff   <= ea_ff;
         unique case (mode_ff)
            smtc_pkg::MODE_MANUAL:  out_torque_ff <= manual_ff;
            smtc_pkg::MODE_SLIDING: out_torque_ff <= torque_ff;
            default:                out_torque_ff <= '0;
         endcase
      end
   end

   assign status.mode     = mode_ff;
   assign status.mul_done = mul_done;

   assign rsp_drive_torque   = out_torque_ff;
   assign rsp_torque_valid   = out_valid_ff;
   assign rsp_active_mode    = out_mode_ff;
   assign rsp_surface_value  = out_surface_ff;
   assign rsp_position_error = out_error_ff;

endmodule
`default_nettype wire

// ===== rtl/core/smtc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smtc_ctrl: sequencer of the torque controller
// Takes an item, picks the mode, in sliding mode walks the product program
// through the shared multiplier, and hands the result to the output register.
// ----------------------------------------------------------------------------
module smtc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire smtc_pkg::status_type  status,
   output smtc_pkg::cmd_type          cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_ISSUE    = 3'd2;
   localparam logic [2:0] ST_WAIT     = 3'd3;
   localparam logic [2:0] ST_INTEG    = 3'd4;
   localparam logic [2:0] ST_RESULT   = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [smtc_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   smtc_pkg::step_type            step_cur;

   assign step_cur = smtc_pkg::step_op(step_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.opnd_sel = step_cur.opnd_sel;
      cmd.gain_sel = step_cur.gain_sel;
      cmd.post     = step_cur.post;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            step_in  = smtc_pkg::STEP_FIRST;
            state_in = (status.mode == smtc_pkg::MODE_SLIDING) ? ST_ISSUE : ST_RESULT;
         end
         ST_ISSUE: begin
            cmd.start_mul = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.mul_done) begin
               cmd.post_en = 1'b1;
               if (step_ff == smtc_pkg::STEP_FIRST) begin
                  state_in = ST_INTEG;
               end else if (step_ff == smtc_pkg::STEP_LAST) begin
                  state_in = ST_RESULT;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_INTEG: begin
            // surface is settled, fold it into the integral
            cmd.int_update = 1'b1;
            step_in        = step_ff + 1'b1;
            state_in       = ST_ISSUE;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_done_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> state_ff == ST_WAIT)
      else $error("multiplier finished outside of a wait");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |-> step_ff <= smtc_pkg::STEP_LAST)
      else $error("step counter past end of program");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_DISPATCH)
      else $error("accepted item not dispatched");

endmodule
`default_nettype wire
